// ===== rtl/vcfe_pkg.sv =====
// ----------------------------------------------------------------------------
// vcfe_pkg
// Shared types, widths and corner tables for the voxel cube face emitter.
// ----------------------------------------------------------------------------
package vcfe_pkg;

	localparam int GRID_SIZE = 1024;
	localparam int COORD_W   = $clog2(GRID_SIZE);
	localparam int MASK_W    = 8;
	localparam int VERT_W    = COORD_W + 2;
	localparam int CORNER_W  = 5;
	localparam int Q_DEPTH   = 2;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	// Face select bits, ordered as bit 1, bit 2, bit 4 of the corner mask
	typedef logic [2:0] face_set_t;

	typedef struct packed {
		face_set_t          faces;
		logic               corner_a;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] cz;
	} cube_cmd_t;

	typedef struct packed {
		logic              [VERT_W-1:0] x;
		logic              [VERT_W-1:0] y;
		logic signed       [VERT_W-1:0] z;
	} vertex_t;

	typedef struct packed {
		logic emit;
		logic last;
		logic pop;
	} back_stat_t;

	// Three corner indices of one triangle; row 0..2 inside faces, 3..5 outside.
	function automatic logic [3*CORNER_W-1:0] tri_corners(input logic [2:0] row,
			input logic tri_sel);
		logic [3*CORNER_W-1:0] c;
		c = '0;
		case ({row, tri_sel})
			4'b000_0: c = {5'd2,  5'd20, 5'd26};
			4'b000_1: c = {5'd2,  5'd26, 5'd8 };
			4'b001_0: c = {5'd20, 5'd18, 5'd24};
			4'b001_1: c = {5'd20, 5'd24, 5'd26};
			4'b010_0: c = {5'd6,  5'd8,  5'd26};
			4'b010_1: c = {5'd6,  5'd26, 5'd24};
			4'b011_0: c = {5'd2,  5'd26, 5'd20};
			4'b011_1: c = {5'd2,  5'd8,  5'd26};
			4'b100_0: c = {5'd24, 5'd18, 5'd20};
			4'b100_1: c = {5'd24, 5'd20, 5'd26};
			4'b101_0: c = {5'd24, 5'd26, 5'd8 };
			4'b101_1: c = {5'd24, 5'd8,  5'd6 };
			default:  c = '0;
		endcase
		return c;
	endfunction

	// Lattice offsets of a corner, each 0 or a full unit (two half units):
	// returned as {depth, y, x} single bits.
	function automatic logic [2:0] corner_ofs(input logic [CORNER_W-1:0] idx);
		logic [2:0] o;
		o = 3'b000;
		case (idx)
			5'd2:    o = 3'b001;
			5'd6:    o = 3'b010;
			5'd8:    o = 3'b011;
			5'd18:   o = 3'b100;
			5'd20:   o = 3'b101;
			5'd24:   o = 3'b110;
			5'd26:   o = 3'b111;
			default: o = 3'b000;
		endcase
		return o;
	endfunction

	function automatic vertex_t make_vertex(input logic [CORNER_W-1:0] idx,
			input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
			input logic [COORD_W-1:0] cz);
		logic [2:0]       o;
		logic [COORD_W:0] sx;
		logic [COORD_W:0] sy;
		logic [COORD_W:0] sd;
		vertex_t          v;
		o  = corner_ofs(idx);
		sx = {1'b0, cx} + {{COORD_W{1'b0}}, o[0]};
		sy = {1'b0, cz} + {{COORD_W{1'b0}}, o[1]};
		sd = {1'b0, cy} + {{COORD_W{1'b0}}, o[2]};
		v.x = {sx, 1'b0};
		v.y = {sy, 1'b0};
		v.z = {VERT_W{1'b0}} - {sd, 1'b0};
		return v;
	endfunction

endpackage

// ===== rtl/vcfe_front.sv =====
// ----------------------------------------------------------------------------
// vcfe_front
// Accepts cubes, works out which faces are exposed, and drops cubes with none.
// ----------------------------------------------------------------------------
module vcfe_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [vcfe_pkg::MASK_W-1:0]    corner_mask,
	input  logic [vcfe_pkg::COORD_W-1:0]   cube_x,
	input  logic [vcfe_pkg::COORD_W-1:0]   cube_y,
	input  logic [vcfe_pkg::COORD_W-1:0]   cube_z,
	input  logic                           q_full,
	output logic                           fr_push,
	output vcfe_pkg::cube_cmd_t            fr_cmd
);
	import vcfe_pkg::*;

	logic      valid_s1;
	cube_cmd_t cmd_s1;
	logic      accept;
	face_set_t bits;
	face_set_t faces;

	always_comb begin
		bits   = {corner_mask[4], corner_mask[2], corner_mask[1]};
		// inside corner: faces where neighbor bit is clear, else where it is set
		faces  = corner_mask[0] ? ~bits : bits;
		full   = valid_s1 && q_full;
		accept = push && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && faces != '0) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && faces != '0) begin
			cmd_s1.faces    <= faces;
			cmd_s1.corner_a <= corner_mask[0];
			cmd_s1.cx       <= cube_x;
			cmd_s1.cy       <= cube_y;
			cmd_s1.cz       <= cube_z;
		end
	end

	assign fr_push = valid_s1 && !q_full;
	assign fr_cmd  = cmd_s1;

endmodule

// ===== rtl/vcfe_queue.sv =====
// ----------------------------------------------------------------------------
// vcfe_queue
// Short command queue between the classifier and the triangle sequencer.
// ----------------------------------------------------------------------------
module vcfe_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  vcfe_pkg::cube_cmd_t   wr_data,
	output logic                  q_full,
	input  logic                  rd_en,
	output logic                  q_valid,
	output vcfe_pkg::cube_cmd_t   rd_data
);
	import vcfe_pkg::*;

	cube_cmd_t          mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign q_full  = count_q == Q_CNT_W'(Q_DEPTH);
	assign q_valid = count_q != '0;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/vcfe_back.sv =====
// ----------------------------------------------------------------------------
// vcfe_back
// Walks the exposed faces of the head cube into the result register, one triangle
// per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module vcfe_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  vcfe_pkg::cube_cmd_t               q_head,
	output vcfe_pkg::back_stat_t              stat,
	output logic                              empty,
	input  logic                              pop,
	output logic        [vcfe_pkg::VERT_W-1:0] v0_x,
	output logic        [vcfe_pkg::VERT_W-1:0] v0_y,
	output logic signed [vcfe_pkg::VERT_W-1:0] v0_z,
	output logic        [vcfe_pkg::VERT_W-1:0] v1_x,
	output logic        [vcfe_pkg::VERT_W-1:0] v1_y,
	output logic signed [vcfe_pkg::VERT_W-1:0] v1_z,
	output logic        [vcfe_pkg::VERT_W-1:0] v2_x,
	output logic        [vcfe_pkg::VERT_W-1:0] v2_y,
	output logic signed [vcfe_pkg::VERT_W-1:0] v2_z,
	output logic                              last_triangle
);
	import vcfe_pkg::*;

	face_set_t             done_q;
	logic                  tri_q;
	logic                  valid_q;
	vertex_t               vtx0_q;
	vertex_t               vtx1_q;
	vertex_t               vtx2_q;
	logic                  last_q;

	face_set_t             active;
	face_set_t             face_oh;
	face_set_t             rest;
	logic [1:0]            face_idx;
	logic [2:0]            row;
	logic [3*CORNER_W-1:0] corners;
	logic                  out_ready;
	logic                  emit;
	logic                  last;

	always_comb begin
		active  = q_head.faces & ~done_q;
		face_oh = active & (~active + 3'd1);
		rest    = active & ~face_oh;
		case (face_oh)
			3'b001:  face_idx = 2'd0;
			3'b010:  face_idx = 2'd1;
			3'b100:  face_idx = 2'd2;
			default: face_idx = 2'd0;
		endcase
		row       = {1'b0, face_idx} + (q_head.corner_a ? 3'd0 : 3'd3);
		corners   = tri_corners(row, tri_q);
		out_ready = !valid_q || pop;
		emit      = q_valid && out_ready;
		last      = tri_q && rest == '0;
	end

	assign stat.emit = emit;
	assign stat.last = last;
	assign stat.pop  = emit && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= '0;
			tri_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				tri_q <= !tri_q;
				if (tri_q) begin
					done_q <= (rest == '0) ? '0 : (done_q | face_oh);
				end
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			vtx0_q <= make_vertex(corners[3*CORNER_W-1:2*CORNER_W],
				q_head.cx, q_head.cy, q_head.cz);
			vtx1_q <= make_vertex(corners[2*CORNER_W-1:CORNER_W],
				q_head.cx, q_head.cy, q_head.cz);
			vtx2_q <= make_vertex(corners[CORNER_W-1:0],
				q_head.cx, q_head.cy, q_head.cz);
			last_q <= last;
		end
	end

	assign empty         = !valid_q;
	assign v0_x          = vtx0_q.x;
	assign v0_y          = vtx0_q.y;
	assign v0_z          = vtx0_q.z;
	assign v1_x          = vtx1_q.x;
	assign v1_y          = vtx1_q.y;
	assign v1_z          = vtx1_q.z;
	assign v2_x          = vtx2_q.x;
	assign v2_y          = vtx2_q.y;
	assign v2_z          = vtx2_q.z;
	assign last_triangle = last_q;

endmodule

// ===== rtl/voxel_cube_face_emitter.sv =====
// Each cube passes the front register, the queue and the result register to the ports.
// Throughput: one triangle per cycle from the sequencer while the result register is
// free or popped; n exposed faces give 2n triangles, and a cube with none is dropped.
// A 2-entry command queue lets the input side run ahead of the sequencer.
// Reset (arst_n low) empties the front register, the queue and the result register.
// ----------------------------------------------------------------------------
// voxel_cube_face_emitter
// Blocky voxel face extraction: one cube in, up to six triangles out.
// ----------------------------------------------------------------------------
module voxel_cube_face_emitter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic        [vcfe_pkg::MASK_W-1:0]  corner_mask,
	input  logic        [vcfe_pkg::COORD_W-1:0] cube_x,
	input  logic        [vcfe_pkg::COORD_W-1:0] cube_y,
	input  logic        [vcfe_pkg::COORD_W-1:0] cube_z,
	output logic                              empty,
	input  logic                              pop,
	output logic        [vcfe_pkg::VERT_W-1:0]  v0_x,
	output logic        [vcfe_pkg::VERT_W-1:0]  v0_y,
	output logic signed [vcfe_pkg::VERT_W-1:0]  v0_z,
	output logic        [vcfe_pkg::VERT_W-1:0]  v1_x,
	output logic        [vcfe_pkg::VERT_W-1:0]  v1_y,
	output logic signed [vcfe_pkg::VERT_W-1:0]  v1_z,
	output logic        [vcfe_pkg::VERT_W-1:0]  v2_x,
	output logic        [vcfe_pkg::VERT_W-1:0]  v2_y,
	output logic signed [vcfe_pkg::VERT_W-1:0]  v2_z,
	output logic                              last_triangle
);
	import vcfe_pkg::*;

	logic       q_full;
	logic       q_valid;
	logic       fr_push;
	cube_cmd_t  fr_cmd;
	cube_cmd_t  q_head;
	back_stat_t bk_stat;

	vcfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.corner_mask (corner_mask),
		.cube_x      (cube_x),
		.cube_y      (cube_y),
		.cube_z      (cube_z),
		.q_full      (q_full),
		.fr_push     (fr_push),
		.fr_cmd      (fr_cmd)
	);

	vcfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_push),
		.wr_data (fr_cmd),
		.q_full  (q_full),
		.rd_en   (bk_stat.pop),
		.q_valid (q_valid),
		.rd_data (q_head)
	);

	vcfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.stat          (bk_stat),
		.empty         (empty),
		.pop           (pop),
		.v0_x          (v0_x),
		.v0_y          (v0_y),
		.v0_z          (v0_z),
		.v1_x          (v1_x),
		.v1_y          (v1_y),
		.v1_z          (v1_z),
		.v2_x          (v2_x),
		.v2_y          (v2_y),
		.v2_z          (v2_z),
		.last_triangle (last_triangle)
	);

	// cubes with no exposed face must never reach the sequencer
	a_head_has_faces: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> q_head.faces != '0)
		else $error("queued cube has no faces");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(fr_push && q_full))
		else $error("command pushed into full queue");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.pop |-> q_valid && bk_stat.emit && bk_stat.last)
		else $error("queue popped before last triangle");

	// a last triangle is never directly followed by another last triangle
	a_last_then_first: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.emit && bk_stat.last |=> !$past(q_valid) || !(bk_stat.emit && bk_stat.last))
		else $error("two last triangles in a row");

endmodule
